// ===== rtl/rdtp_pkg.sv =====
// Shared types, character codes and field positions for the datetime parser.
`default_nettype none

package rdtp_pkg;

	localparam int unsigned CHAR_W = 8;
	localparam int unsigned POS_W  = 5;
	localparam int unsigned OUT_TDATA_W = 48;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_T     = 8'h54;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
	localparam logic [CHAR_W-1:0] CH_Z     = 8'h5A;

	localparam logic [POS_W-1:0] POS_YEAR_0     = 5'd0;
	localparam logic [POS_W-1:0] POS_YEAR_1     = 5'd1;
	localparam logic [POS_W-1:0] POS_YEAR_2     = 5'd2;
	localparam logic [POS_W-1:0] POS_YEAR_3     = 5'd3;
	localparam logic [POS_W-1:0] POS_DASH_0     = 5'd4;
	localparam logic [POS_W-1:0] POS_MONTH_TENS = 5'd5;
	localparam logic [POS_W-1:0] POS_MONTH_UNIT = 5'd6;
	localparam logic [POS_W-1:0] POS_DASH_1     = 5'd7;
	localparam logic [POS_W-1:0] POS_DAY_TENS   = 5'd8;
	localparam logic [POS_W-1:0] POS_DAY_UNIT   = 5'd9;
	localparam logic [POS_W-1:0] POS_DT_SEP     = 5'd10;
	localparam logic [POS_W-1:0] POS_HOUR_TENS  = 5'd11;
	localparam logic [POS_W-1:0] POS_HOUR_UNIT  = 5'd12;
	localparam logic [POS_W-1:0] POS_COLON_0    = 5'd13;
	localparam logic [POS_W-1:0] POS_MIN_TENS   = 5'd14;
	localparam logic [POS_W-1:0] POS_MIN_UNIT   = 5'd15;
	localparam logic [POS_W-1:0] POS_COLON_1    = 5'd16;
	localparam logic [POS_W-1:0] POS_SEC_TENS   = 5'd17;
	localparam logic [POS_W-1:0] POS_SEC_UNIT   = 5'd18;
	localparam logic [POS_W-1:0] POS_LAST       = 5'd19;
	localparam logic [POS_W-1:0] POS_MAX        = 5'd31;

	localparam logic [3:0] MAX_ANY   = 4'd9;
	localparam logic [3:0] MAX_MON_T = 4'd1;
	localparam logic [3:0] MAX_DAY_T = 4'd3;
	localparam logic [3:0] MAX_HR_T  = 4'd2;
	localparam logic [3:0] MAX_MIN_T = 4'd5;

	typedef struct packed {
		logic [6:0]  second;
		logic [5:0]  minute;
		logic [4:0]  hour;
		logic [5:0]  day;
		logic [4:0]  month;
		logic [13:0] year;
		logic        valid_res;
	} res_t;

	localparam int unsigned RES_W = $bits(res_t);

	function automatic logic digit_ok(input logic [CHAR_W-1:0] c, input logic [3:0] maxd);
		logic [CHAR_W-1:0] top;
		top = CH_ZERO + {4'd0, maxd};
		return (c >= CH_ZERO) && (c <= top);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/rdtp_in_stage.sv =====
// Input register for one request byte and its end-of-field flag.
`default_nettype none

module rdtp_in_stage
	import rdtp_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [CHAR_W-1:0] s_tdata,
	input  wire logic              s_tlast,
	input  wire logic              advance,
	output logic                   valid_s1,
	output logic [CHAR_W-1:0]      char_s1,
	output logic                   last_s1
);

	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/rdtp_parse_core.sv =====
// Position counter, error flag, decimal accumulators and per-byte field check.
`default_nettype none

module rdtp_parse_core
	import rdtp_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic [CHAR_W-1:0] char_code,
	input  wire logic              last,
	output res_t                   res
);

	logic [POS_W-1:0] position_q;
	logic             bad_q;
	logic [13:0]      year_q;
	logic [4:0]       month_q;
	logic [5:0]       day_q;
	logic [4:0]       hour_q;
	logic [5:0]       minute_q;
	logic [6:0]       second_q;

	logic [POS_W-1:0] position_n;
	logic             bad_n;
	logic [13:0]      year_n;
	logic [4:0]       month_n;
	logic [5:0]       day_n;
	logic [4:0]       hour_n;
	logic [5:0]       minute_n;
	logic [6:0]       second_n;

	logic [3:0] dig;
	logic       ok;

	assign dig = char_code[3:0];

	always_comb begin
		bad_n    = bad_q;
		year_n   = year_q;
		month_n  = month_q;
		day_n    = day_q;
		hour_n   = hour_q;
		minute_n = minute_q;
		second_n = second_q;
		unique case (position_q)
			POS_YEAR_0, POS_YEAR_1, POS_YEAR_2, POS_YEAR_3: begin
				if (digit_ok(char_code, MAX_ANY)) year_n = year_q * 14'd10 + {10'd0, dig};
				else bad_n = 1'b1;
			end
			POS_DASH_0, POS_DASH_1: begin
				if (char_code != CH_DASH) bad_n = 1'b1;
			end
			POS_MONTH_TENS, POS_MONTH_UNIT: begin
				if (digit_ok(char_code, (position_q == POS_MONTH_TENS) ? MAX_MON_T : MAX_ANY))
					month_n = month_q * 5'd10 + {1'b0, dig};
				else
					bad_n = 1'b1;
			end
			POS_DAY_TENS, POS_DAY_UNIT: begin
				if (digit_ok(char_code, (position_q == POS_DAY_TENS) ? MAX_DAY_T : MAX_ANY))
					day_n = day_q * 6'd10 + {2'd0, dig};
				else
					bad_n = 1'b1;
			end
			POS_DT_SEP: begin
				if (char_code != CH_T && char_code != CH_SPACE) bad_n = 1'b1;
			end
			POS_HOUR_TENS, POS_HOUR_UNIT: begin
				if (digit_ok(char_code, (position_q == POS_HOUR_TENS) ? MAX_HR_T : MAX_ANY))
					hour_n = hour_q * 5'd10 + {1'b0, dig};
				else
					bad_n = 1'b1;
			end
			POS_COLON_0, POS_COLON_1: begin
				if (char_code != CH_COLON) bad_n = 1'b1;
			end
			POS_MIN_TENS, POS_MIN_UNIT: begin
				if (digit_ok(char_code, (position_q == POS_MIN_TENS) ? MAX_MIN_T : MAX_ANY))
					minute_n = minute_q * 6'd10 + {2'd0, dig};
				else
					bad_n = 1'b1;
			end
			POS_SEC_TENS, POS_SEC_UNIT: begin
				if (digit_ok(char_code, MAX_ANY)) second_n = second_q * 7'd10 + {3'd0, dig};
				else bad_n = 1'b1;
			end
			POS_LAST: begin
				if (char_code != CH_Z) bad_n = 1'b1;
			end
			default: begin
				bad_n = 1'b1;
			end
		endcase
		position_n = (position_q == POS_MAX) ? POS_MAX : position_q + 5'd1;
	end

	assign ok = !bad_n && (position_q == POS_LAST);

	always_comb begin
		res.valid_res = ok;
		res.year      = ok ? year_n   : '0;
		res.month     = ok ? month_n  : '0;
		res.day       = ok ? day_n    : '0;
		res.hour      = ok ? hour_n   : '0;
		res.minute    = ok ? minute_n : '0;
		res.second    = ok ? second_n : '0;
	end

	// clear all on reset and at a field's end; other steps advance position, error flag and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
			bad_q      <= 1'b0;
			year_q     <= '0;
			month_q    <= '0;
			day_q      <= '0;
			hour_q     <= '0;
			minute_q   <= '0;
			second_q   <= '0;
		end else if (step) begin
			if (last) begin
				position_q <= '0;
				bad_q      <= 1'b0;
				year_q     <= '0;
				month_q    <= '0;
				day_q      <= '0;
				hour_q     <= '0;
				minute_q   <= '0;
				second_q   <= '0;
			end else begin
				position_q <= position_n;
				bad_q      <= bad_n;
				year_q     <= year_n;
				month_q    <= month_n;
				day_q      <= day_n;
				hour_q     <= hour_n;
				minute_q   <= minute_n;
				second_q   <= second_n;
			end
		end
	end

	a_clear_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		step && last |=> position_q == '0 && !bad_q && year_q == '0)
		else $error("parser state not cleared after last byte");

	a_pos_count: assert property (@(posedge clk) disable iff (!arst_n)
		step && !last && position_q != POS_MAX |=> position_q == $past(position_q) + 5'd1)
		else $error("position did not advance");

	a_pos_sat: assert property (@(posedge clk) disable iff (!arst_n)
		step && !last && position_q == POS_MAX |=> position_q == POS_MAX)
		else $error("position did not saturate");

	a_valid_len: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.valid_res |-> position_q == POS_LAST && !bad_q)
		else $error("valid result on wrong length or after a bad byte");

endmodule

`default_nettype wire

// ===== rtl/rdtp_out_reg.sv =====
// Result register holding one parsed datetime until the consumer takes it.
`default_nettype none

module rdtp_out_reg
	import rdtp_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic load,
	input  res_t      res_d,
	output logic      free,
	output logic      m_tvalid,
	input  wire logic m_tready,
	output res_t      res_q
);

	assign free = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/rfc3339_datetime_field_parser.sv =====
// A field's final byte passes the input register, then the result register drives m_tvalid.
// Throughput: one byte per cycle unless stalled; m_tready reaches s_tready combinationally.
// A final byte waits in the input register only while an untaken result blocks the output.
// Reset (arst_n low) clears the position counter, error flag, accumulators and valid flags.
`default_nettype none

module rfc3339_datetime_field_parser
	import rdtp_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [CHAR_W-1:0]      s_tdata,  // char_code
	input  wire logic                   s_tlast,  // last
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_TDATA_W-1:0]      m_tdata   // valid_res, year, month, day, hour, minute, second, zero pad
);

	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              last_s1;
	logic              advance;
	logic              out_free;
	res_t              res_d;
	res_t              res_q;

	assign advance = valid_s1 && (!last_s1 || out_free);

	rdtp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.char_s1  (char_s1),
		.last_s1  (last_s1)
	);

	rdtp_parse_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.char_code (char_s1),
		.last      (last_s1),
		.res       (res_d)
	);

	rdtp_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && last_s1),
		.res_d    (res_d),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.res_q    (res_q)
	);

	assign m_tdata = {{(OUT_TDATA_W - RES_W){1'b0}}, res_q};

endmodule

`default_nettype wire

// ===== test/rfc3339_datetime_field_parser_tb.sv =====
// Self-checking testbench for the RFC 3339 UTC datetime field parser with stream-side stalls.
`default_nettype none

module rfc3339_datetime_field_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rdtp_pkg::*;

	localparam int RANDOM_BYTES = 700;
	localparam int QUIET_BYTES  = 120;
	localparam int STALL_LIMIT  = 1000;
	localparam int DRAIN_CYCLES = 8;

	class datetime_scoreboard;
		logic [POS_W-1:0] pos;
		bit               bad;
		logic [13:0]      yr;
		logic [4:0]       mon;
		logic [5:0]       dy;
		logic [4:0]       hr;
		logic [5:0]       mi;
		logic [6:0]       se;
		res_t             parsed_due[$];
		int               errors;
		int               checked;
		int               valid_seen;

		function new();
			errors = 0;
			checked = 0;
			valid_seen = 0;
			restart();
		endfunction

		function void restart();
			pos = '0;
			bad = 1'b0;
			yr = '0;
			mon = '0;
			dy = '0;
			hr = '0;
			mi = '0;
			se = '0;
		endfunction

		function bit take(input logic [7:0] c, input logic [3:0] maxd, output int d);
			d = int'(c) - int'(CH_ZERO);
			return d >= 0 && d <= int'(maxd);
		endfunction

		function void parse_byte(input logic [7:0] c, input bit l);
			logic [POS_W-1:0] here;
			int               d;
			res_t             r;
			here = pos;
			case (pos)
				POS_YEAR_0, POS_YEAR_1, POS_YEAR_2, POS_YEAR_3: begin
					if (take(c, MAX_ANY, d)) yr = 14'(yr * 10 + d);
					else bad = 1'b1;
				end
				POS_DASH_0, POS_DASH_1: begin
					if (c != CH_DASH) bad = 1'b1;
				end
				POS_MONTH_TENS: begin
					if (take(c, MAX_MON_T, d)) mon = 5'(mon * 10 + d);
					else bad = 1'b1;
				end
				POS_MONTH_UNIT: begin
					if (take(c, MAX_ANY, d)) mon = 5'(mon * 10 + d);
					else bad = 1'b1;
				end
				POS_DAY_TENS: begin
					if (take(c, MAX_DAY_T, d)) dy = 6'(dy * 10 + d);
					else bad = 1'b1;
				end
				POS_DAY_UNIT: begin
					if (take(c, MAX_ANY, d)) dy = 6'(dy * 10 + d);
					else bad = 1'b1;
				end
				POS_DT_SEP: begin
					if (c != CH_T && c != CH_SPACE) bad = 1'b1;
				end
				POS_HOUR_TENS: begin
					if (take(c, MAX_HR_T, d)) hr = 5'(hr * 10 + d);
					else bad = 1'b1;
				end
				POS_HOUR_UNIT: begin
					if (take(c, MAX_ANY, d)) hr = 5'(hr * 10 + d);
					else bad = 1'b1;
				end
				POS_COLON_0, POS_COLON_1: begin
					if (c != CH_COLON) bad = 1'b1;
				end
				POS_MIN_TENS: begin
					if (take(c, MAX_MIN_T, d)) mi = 6'(mi * 10 + d);
					else bad = 1'b1;
				end
				POS_MIN_UNIT: begin
					if (take(c, MAX_ANY, d)) mi = 6'(mi * 10 + d);
					else bad = 1'b1;
				end
				POS_SEC_TENS, POS_SEC_UNIT: begin
					if (take(c, MAX_ANY, d)) se = 7'(se * 10 + d);
					else bad = 1'b1;
				end
				POS_LAST: begin
					if (c != CH_Z) bad = 1'b1;
				end
				default: begin
					bad = 1'b1;
				end
			endcase
			if (pos != POS_MAX) pos = pos + 1'b1;
			if (l) begin
				r = '0;
				if (!bad && here == POS_LAST) begin
					r.valid_res = 1'b1;
					r.year = yr;
					r.month = mon;
					r.day = dy;
					r.hour = hr;
					r.minute = mi;
					r.second = se;
					valid_seen++;
				end
				parsed_due.push_back(r);
				restart();
			end
		endfunction

		function void compare(input string name, input logic [31:0] want, input logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_parsed(input logic [OUT_TDATA_W-1:0] tdata);
			res_t got;
			res_t want;
			got = res_t'(tdata[RES_W-1:0]);
			if (parsed_due.size() == 0) begin
				$error("result with no field pending: %h", tdata);
				errors++;
				return;
			end
			want = parsed_due.pop_front();
			checked++;
			compare("valid_res", 32'(want.valid_res), 32'(got.valid_res));
			compare("year", 32'(want.year), 32'(got.year));
			compare("month", 32'(want.month), 32'(got.month));
			compare("day", 32'(want.day), 32'(got.day));
			compare("hour", 32'(want.hour), 32'(got.hour));
			compare("minute", 32'(want.minute), 32'(got.minute));
			compare("second", 32'(want.second), 32'(got.second));
			compare("pad", 0, 32'(tdata[OUT_TDATA_W-1:RES_W]));
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [CHAR_W-1:0]      s_tdata = '0;   // char_code
	logic                   s_tlast = 1'b0; // last
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;        // valid_res, year, month, day, hour, minute, second, pad

	datetime_scoreboard sb;
	logic [7:0]         field_q[$];
	bit                 quiet = 1'b0;
	int                 sent_bytes = 0;
	int                 sent_fields = 0;
	int                 idle_cycles = 0;
	int                 stall_left = 0;

	rfc3339_datetime_field_parser uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) sb.check_parsed(m_tdata);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (stall_left != 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			m_tready <= 1'b0;
			stall_left <= $urandom_range(0, 4);
		end else begin
			m_tready <= 1'b1;
		end
	end

	initial begin
		while (idle_cycles < STALL_LIMIT) @(posedge clk);
		$display("rfc3339_datetime_field_parser verification failed");
		$finish;
	end

	function automatic int digit_bound(input logic [POS_W-1:0] p);
		case (p)
			POS_MONTH_TENS: return int'(MAX_MON_T);
			POS_DAY_TENS: return int'(MAX_DAY_T);
			POS_HOUR_TENS: return int'(MAX_HR_T);
			POS_MIN_TENS: return int'(MAX_MIN_T);
			POS_DASH_0, POS_DASH_1, POS_DT_SEP, POS_COLON_0, POS_COLON_1, POS_LAST: return -1;
			default: return int'(MAX_ANY);
		endcase
	endfunction

	function automatic logic [7:0] good_char(input logic [POS_W-1:0] p, input bit hi);
		int b;
		int d;
		b = digit_bound(p);
		if (b >= 0) begin
			case ($urandom_range(0, 3))
				0: d = 0;
				1: d = b;
				default: d = $urandom_range(0, b);
			endcase
			if (hi) d = b;
			return 8'(int'(CH_ZERO) + d);
		end
		case (p)
			POS_DASH_0, POS_DASH_1: return CH_DASH;
			POS_COLON_0, POS_COLON_1: return CH_COLON;
			POS_LAST: return CH_Z;
			default: return (hi || $urandom_range(0, 1)) ? CH_SPACE : CH_T;
		endcase
	endfunction

	function automatic logic [7:0] near_miss(input logic [POS_W-1:0] p);
		int b;
		b = digit_bound(p);
		if (b < 0) return 8'($urandom_range(0, 255));
		return $urandom_range(0, 1) ? 8'(int'(CH_ZERO) - 1) : 8'(int'(CH_ZERO) + b + 1);
	endfunction

	function automatic void build_datetime(input bit hi);
		field_q.delete();
		for (int p = 0; p <= int'(POS_LAST); p++) field_q.push_back(good_char(POS_W'(p), hi));
	endfunction

	task automatic send_byte(input logic [7:0] c, input bit l);
		s_tvalid <= 1'b1;
		s_tdata <= c;
		s_tlast <= l;
		do @(posedge clk); while (!s_tready);
		sb.parse_byte(c, l);
		sent_bytes++;
	endtask

	task automatic send_field();
		for (int i = 0; i < field_q.size(); i++) begin
			send_byte(field_q[i], i == field_q.size() - 1);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
		end
		sent_fields++;
	endtask

	initial begin
		int  kind;
		int  n;
		int  total;
		bit  paused;
		sb = new();
		paused = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		build_datetime(1'b1);
		send_field();
		field_q = '{8'hFF};
		send_field();
		field_q = '{8'h2F, 8'h3A, 8'h00};
		send_field();

		total = sent_bytes + RANDOM_BYTES;
		while (sent_bytes < total) begin
			if (!paused && sent_bytes >= total / 2) begin
				s_tvalid <= 1'b0;
				while (sb.parsed_due.size() != 0) @(posedge clk);
				paused = 1'b1;
			end
			if (sent_bytes >= total - QUIET_BYTES) quiet = 1'b1;
			kind = $urandom_range(0, 99);
			build_datetime(1'b0);
			if (kind < 55) begin
			end else if (kind < 72) begin
				n = $urandom_range(0, int'(POS_LAST));
				field_q[n] = $urandom_range(0, 1) ? near_miss(POS_W'(n)) :
					8'($urandom_range(0, 255));
			end else if (kind < 82) begin
				n = $urandom_range(1, int'(POS_LAST));
				field_q = field_q[0:n-1];
			end else if (kind < 91) begin
				repeat ($urandom_range(1, 15)) field_q.push_back(8'($urandom_range(0, 255)));
			end else begin
				field_q.delete();
				repeat ($urandom_range(1, 40)) field_q.push_back(8'($urandom_range(0, 255)));
			end
			send_field();
		end
		s_tvalid <= 1'b0;

		while (sb.parsed_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d bytes in %0d fields, clean, corrupted, short, long and noise.",
			sent_bytes, sent_fields);
		$display("Checked %0d parse results, %0d of them valid datetimes.",
			sb.checked, sb.valid_seen);
		if (sb.errors == 0 && sb.parsed_due.size() == 0) begin
			$display("rfc3339_datetime_field_parser verification clean");
		end else begin
			$display("rfc3339_datetime_field_parser verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== rfc3339_datetime_field_parser.f =====
rtl/rdtp_pkg.sv
rtl/rdtp_in_stage.sv
rtl/rdtp_parse_core.sv
rtl/rdtp_out_reg.sv
rtl/rfc3339_datetime_field_parser.sv
test/rfc3339_datetime_field_parser_tb.sv
